// ----- hw/rtl/fad_pkg.sv -----
// ----------------------------------------------------------------------------
// fad_pkg
// shared types and constants of the fractional allpass delay
// ----------------------------------------------------------------------------
package fad_pkg;

    // payload widths
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 20;
    localparam int GAIN_W   = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sample saturation limits
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RDB,
        S_RDA,
        S_DIFF,
        S_MR,
        S_R,
        S_MV,
        S_V,
        S_MY,
        S_Y
    } t_state;

endpackage

// ----- hw/rtl/fad_if.sv -----
// ----------------------------------------------------------------------------
// fad_if
// request channels of the fractional allpass delay
// ----------------------------------------------------------------------------

// input channel: sample and delay time
interface fad_in_if
    import fad_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [DELAY_W-1:0]  delay_time;

    modport source (output valid, output sample_in, output delay_time, input ready);
    modport sink   (input valid, input sample_in, input delay_time, output ready);
endinterface

// output channel: filtered sample
interface fad_out_if
    import fad_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/fad_mem.sv -----
// ----------------------------------------------------------------------------
// fad_mem
// delay line storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fad_mem
    import fad_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic        [AW-1:0]       i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic        [AW-1:0]       i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/fad_mul.sv -----
// ----------------------------------------------------------------------------
// fad_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module fad_mul
    import fad_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    // product holds while the sequencer is not multiplying
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

endmodule

// ----- hw/rtl/fractional_allpass_delay.sv -----
// ----------------------------------------------------------------------------
// fractional_allpass_delay
// schroeder allpass over a circular delay line with a linearly
// interpolated fractional read tap
// ----------------------------------------------------------------------------
// sequence: an accepted request is followed by the two delay line reads, the tap difference,
//   the five products through the one shared multiplier and the output step; a new sample
//   is accepted only once that sequence ends and the output register is free
// reset: synchronous active low; afterwards the delay line is zeroed one
//   entry per cycle, all DEPTH entries, before the first input is accepted
module fractional_allpass_delay
    import fad_pkg::*;
#(
    parameter int DEPTH         = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [GAIN_W-1:0]   i_cfg_wr_data,
    fad_in_if.sink              i_in,
    fad_out_if.source           o_out
);

    localparam int AW  = $clog2(DEPTH);
    localparam int FBW = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;

    localparam logic        [39:0]       D_LO = 40'(3) << FRACTION_BITS;
    localparam logic        [39:0]       D_HI = 40'(DEPTH - 1) << FRACTION_BITS;
    localparam logic signed [PROD_W-1:0] HALF = (PROD_W'(1) <<< FRACTION_BITS) >>> 1;
    localparam logic signed [PROD_W-1:0] RND_V = PROD_W'(1) <<< 14;
    localparam logic signed [PROD_W-1:0] RND_Y = PROD_W'(1) <<< 29;
    localparam logic signed [PROD_W-1:0] UNITY = PROD_W'(1) <<< 30;
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(SAMPLE_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(SAMPLE_MIN);

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] val);
        logic signed [SAMPLE_W-1:0] res;
        if (val > SAT_HI) begin
            res = SAMPLE_W'(SAT_HI);
        end else if (val < SAT_LO) begin
            res = SAMPLE_W'(SAT_LO);
        end else begin
            res = SAMPLE_W'(val);
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic signed [GAIN_W-1:0]   r_gain;
    logic signed [SAMPLE_W-1:0] r_x;
    logic        [AW-1:0]       r_ip;
    logic        [FBW-1:0]      r_frac;
    logic        [AW-1:0]       r_ib;
    logic        [AW-1:0]       r_wp;
    logic        [AW-1:0]       r_clr;
    logic signed [SAMPLE_W-1:0] r_b;
    logic signed [SAMPLE_W:0]   r_diff;
    logic signed [SAMPLE_W-1:0] r_r;
    logic signed [SAMPLE_W-1:0] r_v;
    logic signed [MUL_A_W-1:0]  r_k;
    logic signed [PROD_W-1:0]   r_acc;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       in_take;
    logic                       out_free;
    logic        [39:0]         d_ext;
    logic        [39:0]         d_cl;
    logic        [AW:0]         ib_raw;
    logic        [AW-1:0]       ib;
    logic        [AW-1:0]       ia;
    logic signed [PROD_W-1:0]   r_sum;
    logic signed [PROD_W-1:0]   r_sh;
    logic signed [PROD_W-1:0]   v_sh;
    logic signed [PROD_W-1:0]   v_sum;
    logic signed [SAMPLE_W-1:0] n_v;
    logic signed [PROD_W-1:0]   n_k;
    logic signed [PROD_W-1:0]   y_sum;
    logic signed [PROD_W-1:0]   y_sh;

    logic                       mem_we;
    logic        [AW-1:0]       mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic        [AW-1:0]       mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_prod;

    fad_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fad_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // handshake
    assign in_take     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    // delay clamp
    always_comb begin
        d_ext = 40'(i_in.delay_time);
        if (d_ext < D_LO) begin
            d_cl = D_LO;
        end else if (d_ext > D_HI) begin
            d_cl = D_HI;
        end else begin
            d_cl = d_ext;
        end
    end

    // read tap addresses, wrapped modulo depth
    always_comb begin
        ib_raw = {1'b0, r_wp} - {1'b0, r_ip};
        if (ib_raw[AW]) begin
            ib = AW'(ib_raw + (AW + 1)'(DEPTH));
        end else begin
            ib = ib_raw[AW-1:0];
        end
        if (r_ib == '0) begin
            ia = AW'(DEPTH - 1);
        end else begin
            ia = r_ib - 1'b1;
        end
    end

    // datapath arithmetic on the registered product
    always_comb begin
        r_sum = mul_prod + HALF;
        r_sh  = r_sum >>> FRACTION_BITS;
        v_sum = mul_prod + RND_V;
        v_sh  = (v_sum >>> 15) + PROD_W'(r_x);
        n_v   = sat24(v_sh);
        n_k   = UNITY - mul_prod;
        y_sum = r_acc - (mul_prod <<< 15) + RND_Y;
        y_sh  = y_sum >>> 30;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (in_take) n_state = S_RDB;
            S_RDB:  n_state = S_RDA;
            S_RDA:  n_state = S_DIFF;
            S_DIFF: n_state = S_MR;
            S_MR:   n_state = S_R;
            S_R:    n_state = S_MV;
            S_MV:   n_state = S_V;
            S_V:    n_state = S_MY;
            S_MY:   n_state = S_Y;
            S_Y:    if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    // sequencer outputs: memory ports and multiplier operands
    always_comb begin
        i_in.ready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_wp;
        mem_wdata  = n_v;
        mem_raddr  = r_ib;
        mul_en     = 1'b0;
        mul_a      = MUL_A_W'(r_gain);
        mul_b      = MUL_B_W'(r_gain);
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: i_in.ready = 1'b1;
            S_RDB:  mem_raddr = ib;
            S_RDA:  mem_raddr = ia;
            S_MR: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_diff);
                mul_b  = $signed(MUL_B_W'(r_frac));
            end
            S_R: mul_en = 1'b1;
            S_MV: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'(r_r);
            end
            S_V: begin
                mem_we = 1'b1;
                mul_en = 1'b1;
                mul_a  = r_k;
                mul_b  = MUL_B_W'(r_r);
            end
            S_MY: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'(r_v);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_gain      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (r_state == S_V) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (r_state == S_Y && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x    <= i_in.sample_in;
            r_ip   <= AW'(d_cl >> FRACTION_BITS);
            r_frac <= (FRACTION_BITS > 0) ? FBW'(d_cl) : '0;
        end
        if (r_state == S_RDB) r_ib <= ib;
        if (r_state == S_RDA) r_b <= mem_rdata;
        if (r_state == S_DIFF) r_diff <= (SAMPLE_W + 1)'(mem_rdata) - (SAMPLE_W + 1)'(r_b);
        if (r_state == S_R) r_r <= r_b + SAMPLE_W'(r_sh);
        if (r_state == S_MV) r_k <= MUL_A_W'(n_k);
        if (r_state == S_V) r_v <= n_v;
        if (r_state == S_MY) r_acc <= mul_prod;
        if (r_state == S_Y && out_free) r_out_data <= sat24(y_sh);
    end

    // an accepted sample blocks further requests while it is processed
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !i_in.ready)
        else $error("input ready right after an accepted request");

    // the delay line is written only by the clearing pass or the feedback write
    a_mem_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLR || r_state == S_V))
        else $error("delay line written outside clear or feedback write");

    // the write pointer moves only after the feedback write
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_V && r_state != S_CLR) |=> $stable(r_wp))
        else $error("write pointer moved outside the feedback write");

    // a result is raised only from the output step of the sequencer
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_Y)
        else $error("result raised outside the output step");

endmodule
